// File: hdl/fsbc_pkg.sv
// Package for the frustum sphere/box cull block: widths, codes, the tag that
// travels with each multiply-accumulate term, and the frustum edge table.
// No dependencies.
`timescale 1ns / 1ps

package fsbc_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int VAL_W          = 32;
   localparam int MODE_W         = 2;
   localparam int SLOT_W         = 3;
   localparam int NUM_PLANES     = 6;
   localparam int NUM_CORNERS    = 8;
   localparam int NUM_EDGES      = 6;

   localparam logic [MODE_W-1:0] MODE_LOAD_PLANE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_CORNER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SPHERE      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CUBE        = 2'd3;

   // Where a finished dot product goes.
   localparam logic [1:0] DST_POS  = 2'd0;
   localparam logic [1:0] DST_FRUS = 2'd1;
   localparam logic [1:0] DST_CUBE = 2'd2;

   typedef struct packed {
      logic       vld;
      logic       first;
      logic       last;
      logic       grp_first;
      logic       grp_last;
      logic [1:0] dst;
   } tag_type;

   // Frustum edges run from the head corner to the tail corner.
   function automatic logic [2:0] edge_head(input logic [2:0] e);
      logic [2:0] r;
      case (e)
         3'd0: r = 3'd3;
         3'd1: r = 3'd1;
         3'd2: r = 3'd0;
         3'd3: r = 3'd2;
         3'd4: r = 3'd3;
         3'd5: r = 3'd1;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] edge_tail(input logic [2:0] e);
      logic [2:0] r;
      case (e)
         3'd0: r = 3'd2;
         3'd1: r = 3'd3;
         3'd2: r = 3'd4;
         3'd3: r = 3'd6;
         3'd4: r = 3'd7;
         3'd5: r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/fsbc_if.sv
// Valid/ready channel interfaces for the cull block: query/load input and
// result output. Depends on fsbc_pkg.
`timescale 1ns / 1ps

interface fsbc_req_if;
   import fsbc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [SLOT_W-1:0]        slot;
   logic signed [VAL_W-1:0]  vec_x;
   logic signed [VAL_W-1:0]  vec_y;
   logic signed [VAL_W-1:0]  vec_z;
   logic signed [VAL_W-1:0]  scalar;
   modport source (output valid, mode, slot, vec_x, vec_y, vec_z, scalar, input ready);
   modport sink   (input valid, mode, slot, vec_x, vec_y, vec_z, scalar, output ready);
endinterface

interface fsbc_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic was_cube;
   modport source (output valid, inside_res, was_cube, input ready);
   modport sink   (input valid, inside_res, was_cube, output ready);
endinterface

// File: hdl/fsbc_mac.sv
// Shared multiply-accumulate unit: one term per cycle, a fixed-point product
// floored by FRAC_BITS or op_a as is, then accumulated. Depends on fsbc_pkg.
`timescale 1ns / 1ps

module fsbc_mac #(
   parameter int OPW       = 34,
   parameter int FRAC_BITS = 16,
   parameter int ACCW      = 55
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [OPW-1:0]   op_a,
   input  logic signed [OPW-1:0]   op_b,
   input  logic                    pass_a,
   input  fsbc_pkg::tag_type       tag_in,
   output fsbc_pkg::tag_type       tag_out,
   output logic signed [ACCW-1:0]  sum_out
);
   import fsbc_pkg::*;

   localparam int PW = 2 * OPW;

   logic signed [PW-1:0]   full_prod;
   logic signed [PW-1:0]   shift_prod;
   logic signed [ACCW-1:0] prod_ff;
   logic signed [ACCW-1:0] acc_ff;
   tag_type                tag_ff;

   assign full_prod  = op_a * op_b;
   // Arithmetic shift gives the floor of the exact product.
   assign shift_prod = full_prod >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      prod_ff <= pass_a ? ACCW'(op_a) : ACCW'(shift_prod);
      if (tag_ff.vld) begin
         acc_ff <= sum_out;
      end
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign sum_out = (tag_ff.first ? ACCW'(0) : acc_ff) + prod_ff;
   assign tag_out = tag_ff;

endmodule

// File: hdl/frustum_sphere_box_cull.sv
// Top level of the frustum cull block: plane and corner stores, the query
// sequencer and result register. Depends on fsbc_pkg, fsbc_if, fsbc_mac.
//
//  channel  | dir | handshake      | beat
//  req_ch   | in  | valid / ready  | mode, slot, vec_x, vec_y, vec_z, scalar
//  rsp_ch   | out | valid / ready  | inside_res, was_cube
//
// A load beat is written in the cycle it is accepted; the block stays ready.
// A sphere query issues 30 terms through the one shared multiplier.
// A cube query issues 192 terms for the plane test, 8 corner checks for the
// face test and up to 18 axes of 32 terms each; zero axes are skipped.
// Ready is low while a query runs. The result waits in an output register.
// Reset is synchronous; it clears only the sequencer, MAC tag and result valid.
`timescale 1ns / 1ps

module frustum_sphere_box_cull #(
   parameter int COORD_BITS = fsbc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = fsbc_pkg::FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   fsbc_req_if.sink    req_ch,
   fsbc_rsp_if.source  rsp_ch
);
   import fsbc_pkg::*;

   localparam int IN_W = (COORD_BITS < VAL_W) ? COORD_BITS : VAL_W;
   localparam int PT_W = IN_W + 1;
   localparam int OPW  = IN_W + 2;
   localparam int PW   = 2 * OPW;
   localparam int SHW  = PW - FRAC_BITS;
   localparam int ACCW = ((SHW > OPW) ? SHW : OPW) + 3;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SPH   = 4'd1;
   localparam logic [3:0] S_DRAIN = 4'd2;
   localparam logic [3:0] S_T1    = 4'd3;
   localparam logic [3:0] S_T2    = 4'd4;
   localparam logic [3:0] S_T2CHK = 4'd5;
   localparam logic [3:0] S_EDA   = 4'd6;
   localparam logic [3:0] S_EDB   = 4'd7;
   localparam logic [3:0] S_AXIS  = 4'd8;
   localparam logic [3:0] S_T3    = 4'd9;
   localparam logic [3:0] S_WAIT  = 4'd10;
   localparam logic [3:0] S_CHK   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [2:0] grp_ff, grp_in;
   logic [2:0] term_ff, term_in;
   logic [3:0] pt_ff, pt_in;
   logic [2:0] edge_ff, edge_in;
   logic [1:0] axis_ff, axis_in;

   logic signed [IN_W-1:0] pn_ff [NUM_PLANES][3];
   logic signed [IN_W-1:0] pd_ff [NUM_PLANES];
   logic signed [IN_W-1:0] cr_ff [NUM_CORNERS][3];

   logic signed [IN_W-1:0] q_ff [3];
   logic signed [IN_W-1:0] qs_ff;
   logic signed [PT_W-1:0] lo_ff [3];
   logic signed [PT_W-1:0] hi_ff [3];
   logic                   half_zero_ff;
   logic signed [IN_W-1:0] held_ff [3];
   logic signed [PT_W-1:0] ed_ff [3];
   logic [5:0]             face_ff;
   logic                   any_ff;
   logic                   inside_ff;
   logic signed [ACCW-1:0] fmin_ff, fmax_ff, cmin_ff, cmax_ff;
   logic                   rsp_vld_ff, rsp_inside_ff, rsp_cube_ff;
   logic                   cube_query_ff;

   logic                   req_acc;
   logic signed [IN_W-1:0] in_v [3];
   logic signed [IN_W-1:0] in_s;
   logic signed [IN_W-1:0] in_half;
   logic [2:0]             cidx;
   logic signed [IN_W-1:0] cr_rd [3];
   logic [1:0]             ci;
   logic signed [OPW-1:0]  coef;
   logic signed [PT_W-1:0] cube_pt;
   logic signed [OPW-1:0]  op_a, op_b;
   logic                   pass_a;
   tag_type                tag_issue, mac_tag;
   logic signed [ACCW-1:0] mac_sum;
   logic                   any_next;
   logic                   ax_zero;
   logic [5:0]             face_hit;
   logic                   rsp_load;
   logic                   separated;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign in_v[0] = signed'(req_ch.vec_x[IN_W-1:0]);
   assign in_v[1] = signed'(req_ch.vec_y[IN_W-1:0]);
   assign in_v[2] = signed'(req_ch.vec_z[IN_W-1:0]);
   assign in_s    = signed'(req_ch.scalar[IN_W-1:0]);
   assign in_half = in_s >>> 1;

   always_comb begin
      unique case (state_ff)
         S_EDA:   cidx = edge_head(edge_ff);
         S_EDB:   cidx = edge_tail(edge_ff);
         default: cidx = pt_ff[2:0];
      endcase
   end

   assign cr_rd[0] = cr_ff[cidx][0];
   assign cr_rd[1] = cr_ff[cidx][1];
   assign cr_rd[2] = cr_ff[cidx][2];

   // Operand selection for the shared multiplier.
   always_comb begin
      ci   = term_ff[1:0];
      coef = '0;
      if (state_ff == S_T3) begin
         unique case ({axis_ff, term_ff[0]})
            3'b000:  begin coef = OPW'(ed_ff[2]);    ci = 2'd1; end
            3'b001:  begin coef = -(OPW'(ed_ff[1])); ci = 2'd2; end
            3'b010:  begin coef = -(OPW'(ed_ff[2])); ci = 2'd0; end
            3'b011:  begin coef = OPW'(ed_ff[0]);    ci = 2'd2; end
            3'b100:  begin coef = OPW'(ed_ff[1]);    ci = 2'd0; end
            3'b101:  begin coef = -(OPW'(ed_ff[0])); ci = 2'd1; end
            default: begin coef = '0;                ci = 2'd0; end
         endcase
      end
      cube_pt   = pt_ff[ci] ? hi_ff[ci] : lo_ff[ci];
      op_a      = '0;
      op_b      = '0;
      pass_a    = 1'b0;
      tag_issue = '0;
      unique case (state_ff)
         S_SPH: begin
            tag_issue.vld       = 1'b1;
            tag_issue.first     = (term_ff == 3'd0);
            tag_issue.last      = (term_ff == 3'd4);
            tag_issue.grp_first = 1'b1;
            tag_issue.grp_last  = 1'b1;
            tag_issue.dst       = DST_POS;
            if (term_ff == 3'd3) begin
               op_a   = OPW'(pd_ff[grp_ff]);
               pass_a = 1'b1;
            end else if (term_ff == 3'd4) begin
               op_a   = OPW'(qs_ff);
               pass_a = 1'b1;
            end else begin
               op_a = OPW'(pn_ff[grp_ff][term_ff[1:0]]);
               op_b = OPW'(q_ff[term_ff[1:0]]);
            end
         end
         S_T1: begin
            tag_issue.vld       = 1'b1;
            tag_issue.first     = (term_ff == 3'd0);
            tag_issue.last      = (term_ff == 3'd3);
            tag_issue.grp_first = (pt_ff == 4'd0);
            tag_issue.grp_last  = (pt_ff == 4'd7);
            tag_issue.dst       = DST_POS;
            if (term_ff == 3'd3) begin
               op_a   = OPW'(pd_ff[grp_ff]);
               pass_a = 1'b1;
            end else begin
               op_a = OPW'(pn_ff[grp_ff][term_ff[1:0]]);
               op_b = OPW'(cube_pt);
            end
         end
         S_T3: begin
            tag_issue.vld       = 1'b1;
            tag_issue.first     = (term_ff == 3'd0);
            tag_issue.last      = (term_ff == 3'd1);
            tag_issue.grp_first = (pt_ff[2:0] == 3'd0);
            tag_issue.grp_last  = 1'b0;
            tag_issue.dst       = pt_ff[3] ? DST_CUBE : DST_FRUS;
            op_a = coef;
            op_b = pt_ff[3] ? OPW'(cube_pt) : OPW'(cr_rd[ci]);
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   fsbc_mac #(
      .OPW       (OPW),
      .FRAC_BITS (FRAC_BITS),
      .ACCW      (ACCW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .op_a    (op_a),
      .op_b    (op_b),
      .pass_a  (pass_a),
      .tag_in  (tag_issue),
      .tag_out (mac_tag),
      .sum_out (mac_sum)
   );

   assign any_next = (mac_tag.grp_first ? 1'b0 : any_ff) | (mac_sum > 0);

   always_comb begin
      unique case (axis_ff)
         2'd0:    ax_zero = (ed_ff[1] == 0) && (ed_ff[2] == 0);
         2'd1:    ax_zero = (ed_ff[0] == 0) && (ed_ff[2] == 0);
         default: ax_zero = (ed_ff[0] == 0) && (ed_ff[1] == 0);
      endcase
   end

   assign face_hit[0] = PT_W'(cr_rd[0]) > lo_ff[0];
   assign face_hit[1] = PT_W'(cr_rd[1]) < hi_ff[1];
   assign face_hit[2] = PT_W'(cr_rd[0]) < hi_ff[0];
   assign face_hit[3] = PT_W'(cr_rd[1]) > lo_ff[1];
   assign face_hit[4] = PT_W'(cr_rd[2]) < hi_ff[2];
   assign face_hit[5] = PT_W'(cr_rd[2]) > lo_ff[2];

   assign separated = (fmin_ff > cmax_ff) || (cmin_ff > fmax_ff);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_vld_ff || rsp_ch.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      term_in  = term_ff;
      pt_in    = pt_ff;
      edge_in  = edge_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_ch.mode == MODE_SPHERE || req_ch.mode == MODE_CUBE)) begin
               state_in = (req_ch.mode == MODE_SPHERE) ? S_SPH : S_T1;
               grp_in   = '0;
               term_in  = '0;
               pt_in    = '0;
            end
         end
         S_SPH: begin
            if (term_ff == 3'd4) begin
               term_in = '0;
               if (grp_ff == 3'(NUM_PLANES - 1)) begin
                  state_in = S_DRAIN;
               end else begin
                  grp_in = grp_ff + 3'd1;
               end
            end else begin
               term_in = term_ff + 3'd1;
            end
         end
         S_DRAIN: state_in = S_DONE;
         S_T1: begin
            if (term_ff == 3'd3) begin
               term_in = '0;
               if (pt_ff == 4'd7) begin
                  pt_in = '0;
                  if (grp_ff == 3'(NUM_PLANES - 1)) begin
                     state_in = S_T2;
                  end else begin
                     grp_in = grp_ff + 3'd1;
                  end
               end else begin
                  pt_in = pt_ff + 4'd1;
               end
            end else begin
               term_in = term_ff + 3'd1;
            end
         end
         S_T2: begin
            if (pt_ff == 4'd7) begin
               pt_in    = '0;
               state_in = S_T2CHK;
            end else begin
               pt_in = pt_ff + 4'd1;
            end
         end
         S_T2CHK: begin
            if (half_zero_ff) begin
               state_in = S_DONE;
            end else begin
               edge_in  = '0;
               state_in = S_EDA;
            end
         end
         S_EDA: state_in = S_EDB;
         S_EDB: begin
            axis_in  = '0;
            state_in = S_AXIS;
         end
         S_AXIS, S_CHK: begin
            if (state_ff == S_AXIS && !ax_zero) begin
               pt_in    = '0;
               term_in  = '0;
               state_in = S_T3;
            end else if (axis_ff == 2'd2) begin
               if (edge_ff == 3'(NUM_EDGES - 1)) begin
                  state_in = S_DONE;
               end else begin
                  edge_in  = edge_ff + 3'd1;
                  state_in = S_EDA;
               end
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_AXIS;
            end
         end
         S_T3: begin
            if (term_ff == 3'd1) begin
               term_in = '0;
               if (pt_ff == 4'd15) begin
                  state_in = S_WAIT;
               end else begin
                  pt_in = pt_ff + 4'd1;
               end
            end else begin
               term_in = term_ff + 3'd1;
            end
         end
         S_WAIT: state_in = S_CHK;
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         grp_ff     <= '0;
         term_ff    <= '0;
         pt_ff      <= '0;
         edge_ff    <= '0;
         axis_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         term_ff  <= term_in;
         pt_ff    <= pt_in;
         edge_ff  <= edge_in;
         axis_ff  <= axis_in;
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Stores, query operands and test results.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         unique case (req_ch.mode)
            MODE_LOAD_PLANE: begin
               if (req_ch.slot < SLOT_W'(NUM_PLANES)) begin
                  pn_ff[req_ch.slot][0] <= in_v[0];
                  pn_ff[req_ch.slot][1] <= in_v[1];
                  pn_ff[req_ch.slot][2] <= in_v[2];
                  pd_ff[req_ch.slot]    <= in_s;
               end
            end
            MODE_LOAD_CORNER: begin
               cr_ff[req_ch.slot][0] <= in_v[0];
               cr_ff[req_ch.slot][1] <= in_v[1];
               cr_ff[req_ch.slot][2] <= in_v[2];
            end
            default: begin
               for (int k = 0; k < 3; k++) begin
                  q_ff[k]  <= in_v[k];
                  lo_ff[k] <= PT_W'(in_v[k]) - PT_W'(in_half);
                  hi_ff[k] <= PT_W'(in_v[k]) + PT_W'(in_half);
               end
               qs_ff        <= in_s;
               half_zero_ff <= (in_half == 0);
               inside_ff    <= 1'b1;
            end
         endcase
      end
      if (state_ff == S_T2) begin
         face_ff <= ((pt_ff == 4'd0) ? 6'd0 : face_ff) | face_hit;
      end
      if (state_ff == S_EDA) begin
         held_ff <= cr_rd;
      end
      if (state_ff == S_EDB) begin
         for (int k = 0; k < 3; k++) begin
            ed_ff[k] <= PT_W'(held_ff[k]) - PT_W'(cr_rd[k]);
         end
      end
      if (mac_tag.vld && mac_tag.last) begin
         unique case (mac_tag.dst)
            DST_POS: begin
               any_ff <= any_next;
               if (mac_tag.grp_last && !any_next) begin
                  inside_ff <= 1'b0;
               end
            end
            DST_FRUS: begin
               if (mac_tag.grp_first || mac_sum < fmin_ff) fmin_ff <= mac_sum;
               if (mac_tag.grp_first || mac_sum > fmax_ff) fmax_ff <= mac_sum;
            end
            DST_CUBE: begin
               if (mac_tag.grp_first || mac_sum < cmin_ff) cmin_ff <= mac_sum;
               if (mac_tag.grp_first || mac_sum > cmax_ff) cmax_ff <= mac_sum;
            end
            default: begin
               any_ff <= any_ff;
            end
         endcase
      end
      if (state_ff == S_T2CHK && face_ff != 6'h3F) begin
         inside_ff <= 1'b0;
      end
      if (state_ff == S_CHK && separated) begin
         inside_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_inside_ff <= inside_ff;
         rsp_cube_ff   <= cube_query_ff;
      end
   end

   // Query kind, kept for the result beat.
   always_ff @(posedge clock) begin
      if (req_acc && (req_ch.mode == MODE_SPHERE || req_ch.mode == MODE_CUBE)) begin
         cube_query_ff <= (req_ch.mode == MODE_CUBE);
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.inside_res = rsp_inside_ff;
   assign rsp_ch.was_cube   = rsp_cube_ff;

endmodule

// File: hdl/fsbc_checker.sv
// Port-level checker for the frustum cull block, bound to the top level.
// Depends on fsbc_pkg and the top-level interfaces.
`timescale 1ns / 1ps

module fsbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_inside,
   input logic        rsp_cube
);
   import fsbc_pkg::*;

   logic query_beat;
   logic load_beat;

   assign query_beat = req_valid && req_ready
                       && (req_mode == MODE_SPHERE || req_mode == MODE_CUBE);
   assign load_beat  = req_valid && req_ready
                       && (req_mode == MODE_LOAD_PLANE || req_mode == MODE_LOAD_CORNER);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A query keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset) query_beat |=> !req_ready)
      else $error("ready after query beat");

   // A load never makes the block busy.
   assert property (@(posedge clock) disable iff (reset) load_beat |=> req_ready)
      else $error("busy after load beat");

   // A result appears only at the end of a busy period.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a running query");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside) && $stable(rsp_cube))
      else $error("stalled result changed");

endmodule

bind frustum_sphere_box_cull fsbc_checker u_fsbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_mode   (req_ch.mode),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_inside (rsp_ch.inside_res),
   .rsp_cube   (rsp_ch.was_cube)
);
